// ===== src/bfr_pkg.sv =====
// Shared types, constants and register codes of the 3x3 box filter.
`timescale 1ns / 1ps

package bfr_pkg;

    localparam int MAX_WIDTH_DEF    = 2048;
    localparam int CHANNEL_BITS_DEF = 8;

    localparam int NCH          = 4;
    localparam int IN_BITS      = 8;
    localparam int OUT_BITS     = 8;
    localparam int DIVISOR      = 9;
    localparam int MIN_DIM      = 3;
    localparam int HEIGHT_LIMIT = 4096;

    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 13;
    localparam int WIDTH_REG_W  = 12;
    localparam int HEIGHT_REG_W = 13;
    localparam int COL_OUT_W    = 11;
    localparam int ROW_W        = 12;

    // Lane order of the channels.
    localparam int CH_RED   = 0;
    localparam int CH_GREEN = 1;
    localparam int CH_BLUE  = 2;
    localparam int CH_ALPHA = 3;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FOUR_CHANNELS = 2'd2;

    typedef struct packed {
        logic [IN_BITS-1:0] red_in;
        logic [IN_BITS-1:0] green_in;
        logic [IN_BITS-1:0] blue_in;
        logic [IN_BITS-1:0] alpha_in;
    } pix_in_t;

    typedef struct packed {
        logic [OUT_BITS-1:0]  red_out;
        logic [OUT_BITS-1:0]  green_out;
        logic [OUT_BITS-1:0]  blue_out;
        logic [OUT_BITS-1:0]  alpha_out;
        logic [COL_OUT_W-1:0] center_col;
        logic [ROW_W-1:0]     center_row;
        logic                 last_of_frame;
    } pix_out_t;

    typedef struct packed {
        logic [COL_OUT_W-1:0] center_col;
        logic [ROW_W-1:0]     center_row;
        logic                 last_of_frame;
    } meta_t;

    typedef struct packed {
        logic shift;
        logic sum_load;
    } lane_ctl_t;

    typedef logic [NCH-1:0][OUT_BITS-1:0] mean_vec_t;

endpackage

// ===== src/box_filter_3x3_rgba_top.sv =====
// Top level of the 3x3 box (mean) filter over a raster RGBA pixel stream.
`timescale 1ns / 1ps

// The block takes one pixel per clock in raster order and sustains that rate: each line
// store is read once and written once per pixel through its own ports. A pixel at column x,
// row y with x >= 2 and y >= 2 yields the mean of the 3x3 neighborhood of (x-1, y-1); the
// result is registered in order after the input beat is taken (line store read with the pixel
// register at the accepting edge, then the window sum, then the divide into the output
// register). A held result stalls the pipeline behind it, and the input stalls once all
// three stages are full. Border pixels yield no beat. A write to any known register restarts
// the frame at column 0, row 0; width and height are clamped to their legal range. Alpha is
// filtered only when four_channels is set and reads zero otherwise.

module box_filter_3x3_rgba_top #(
    parameter int MAX_WIDTH    = bfr_pkg::MAX_WIDTH_DEF,
    parameter int CHANNEL_BITS = bfr_pkg::CHANNEL_BITS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  bfr_pkg::pix_in_t                 in_data,
    output logic                             out_valid,
    input  logic                             out_ready,
    output bfr_pkg::pix_out_t                out_data,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [bfr_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [bfr_pkg::CFG_DATA_W-1:0]   cfg_data
);

    localparam int CW   = $clog2(MAX_WIDTH);
    localparam int WW   = $clog2(MAX_WIDTH + 1);
    localparam int CMPW = (WW > bfr_pkg::WIDTH_REG_W) ? WW : bfr_pkg::WIDTH_REG_W;
    localparam int HW   = bfr_pkg::HEIGHT_REG_W;
    localparam int RW   = bfr_pkg::ROW_W;
    localparam int MW   = bfr_pkg::NCH * CHANNEL_BITS;

    typedef logic [bfr_pkg::NCH-1:0][CHANNEL_BITS-1:0] chan_vec_t;

    // Configuration registers.
    logic [bfr_pkg::WIDTH_REG_W-1:0]  width_reg;
    logic [bfr_pkg::HEIGHT_REG_W-1:0] height_reg;
    logic                             four_reg;
    logic                             restart;

    // Position of the next input pixel.
    logic [CW-1:0] col_reg;
    logic [RW-1:0] row_reg;

    logic [CMPW-1:0] w_raw;
    logic [WW-1:0]   w_eff;
    logic [HW-1:0]   h_eff;
    logic            col_wrap;
    logic            row_wrap;
    logic            in_fire;

    // Stage 1: pixel waiting for its line store samples.
    logic           v1_reg;
    logic           res1_reg;
    logic [CW-1:0]  addr1_reg;
    chan_vec_t      cur1_reg;
    bfr_pkg::meta_t meta1_reg;
    bfr_pkg::meta_t meta_in;

    // Stage 2: window sums held in the lanes.
    logic           v2_reg;
    bfr_pkg::meta_t meta2_reg;

    logic out_valid_reg;

    logic s1_free;
    logic s2_free;
    logic s3_free;
    logic proc1;
    logic move2;

    chan_vec_t          cur_in;
    chan_vec_t          rd_up;
    chan_vec_t          rd_mid;
    bfr_pkg::lane_ctl_t lane_ctl;
    bfr_pkg::mean_vec_t means;

    assign cfg_ready = 1'b1;
    assign restart   = cfg_valid && (cfg_index == bfr_pkg::CFG_IMAGE_WIDTH
                                  || cfg_index == bfr_pkg::CFG_IMAGE_HEIGHT
                                  || cfg_index == bfr_pkg::CFG_FOUR_CHANNELS);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= bfr_pkg::WIDTH_REG_W'(640);
            height_reg <= bfr_pkg::HEIGHT_REG_W'(480);
            four_reg   <= 1'b0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                bfr_pkg::CFG_IMAGE_WIDTH:
                begin
                    width_reg <= cfg_data[bfr_pkg::WIDTH_REG_W-1:0];
                end
                bfr_pkg::CFG_IMAGE_HEIGHT:
                begin
                    height_reg <= cfg_data[bfr_pkg::HEIGHT_REG_W-1:0];
                end
                bfr_pkg::CFG_FOUR_CHANNELS:
                begin
                    four_reg <= cfg_data[0];
                end
                default:
                begin
                end
            endcase
        end
    end

    // Clamp the frame size to the range the line stores and counters support.
    always_comb
    begin
        w_raw = CMPW'(width_reg);
        if (w_raw < CMPW'(bfr_pkg::MIN_DIM))
        begin
            w_eff = WW'(bfr_pkg::MIN_DIM);
        end
        else if (w_raw > CMPW'(MAX_WIDTH))
        begin
            w_eff = WW'(MAX_WIDTH);
        end
        else
        begin
            w_eff = WW'(w_raw);
        end

        if (height_reg < HW'(bfr_pkg::MIN_DIM))
        begin
            h_eff = HW'(bfr_pkg::MIN_DIM);
        end
        else if (height_reg > HW'(bfr_pkg::HEIGHT_LIMIT))
        begin
            h_eff = HW'(bfr_pkg::HEIGHT_LIMIT);
        end
        else
        begin
            h_eff = height_reg;
        end
    end

    assign col_wrap = (WW'(col_reg) + WW'(1)) >= w_eff;
    assign row_wrap = (HW'(row_reg) + HW'(1)) >= h_eff;

    always_comb
    begin
        meta_in.center_col    = bfr_pkg::COL_OUT_W'(col_reg - CW'(1));
        meta_in.center_row    = row_reg - RW'(1);
        meta_in.last_of_frame = (WW'(col_reg) == (w_eff - WW'(1)))
                             && (HW'(row_reg) == (h_eff - HW'(1)));
    end

    // Pipeline flow: a stage moves on when the stage after it is empty or moving too.
    assign s3_free  = !out_valid_reg || out_ready;
    assign s2_free  = !v2_reg || s3_free;
    assign s1_free  = !v1_reg || s2_free;
    assign proc1    = v1_reg && s2_free;
    assign move2    = v2_reg && s3_free;
    assign in_ready = s1_free;
    assign in_fire  = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (restart)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (in_fire)
        begin
            if (col_wrap)
            begin
                col_reg <= '0;
                row_reg <= row_wrap ? '0 : row_reg + RW'(1);
            end
            else
            begin
                col_reg <= col_reg + CW'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_fire)
            begin
                v1_reg <= 1'b1;
            end
            else if (proc1)
            begin
                v1_reg <= 1'b0;
            end

            if (proc1)
            begin
                v2_reg <= res1_reg;
            end
            else if (move2)
            begin
                v2_reg <= 1'b0;
            end

            if (move2)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_comb
    begin
        cur_in[bfr_pkg::CH_RED]   = CHANNEL_BITS'(in_data.red_in);
        cur_in[bfr_pkg::CH_GREEN] = CHANNEL_BITS'(in_data.green_in);
        cur_in[bfr_pkg::CH_BLUE]  = CHANNEL_BITS'(in_data.blue_in);
        cur_in[bfr_pkg::CH_ALPHA] = CHANNEL_BITS'(in_data.alpha_in);
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            res1_reg  <= (col_reg >= CW'(2)) && (row_reg >= RW'(2));
            addr1_reg <= col_reg;
            cur1_reg  <= cur_in;
            meta1_reg <= meta_in;
        end
        if (proc1)
        begin
            meta2_reg <= meta1_reg;
        end
    end

    // The upper store takes what the middle store held; the middle store takes the new pixel.
    bfr_line_mem #(
        .DEPTH (MAX_WIDTH),
        .WIDTH (MW)
    ) u_upper (
        .clk   (clk),
        .we    (proc1),
        .waddr (addr1_reg),
        .wdata (rd_mid),
        .re    (in_fire),
        .raddr (col_reg),
        .rdata (rd_up)
    );

    bfr_line_mem #(
        .DEPTH (MAX_WIDTH),
        .WIDTH (MW)
    ) u_middle (
        .clk   (clk),
        .we    (proc1),
        .waddr (addr1_reg),
        .wdata (cur1_reg),
        .re    (in_fire),
        .raddr (col_reg),
        .rdata (rd_mid)
    );

    assign lane_ctl.shift    = proc1;
    assign lane_ctl.sum_load = proc1 && res1_reg;

    for (genvar c = 0; c < bfr_pkg::NCH; c++)
    begin : g_lane
        bfr_lane #(
            .CHANNEL_BITS (CHANNEL_BITS)
        ) u_lane (
            .clk  (clk),
            .ctl  (lane_ctl),
            .up   (rd_up[c]),
            .mid  (rd_mid[c]),
            .cur  (cur1_reg[c]),
            .mean (means[c])
        );
    end

    bfr_merge u_merge (
        .clk           (clk),
        .load          (move2),
        .four_channels (four_reg),
        .means         (means),
        .meta          (meta2_reg),
        .result        (out_data)
    );

    assign out_valid = out_valid_reg;

endmodule

// ===== src/bfr_line_mem.sv =====
// Line store memory: one write port and one registered read port.
`timescale 1ns / 1ps

module bfr_line_mem #(
    parameter int DEPTH = bfr_pkg::MAX_WIDTH_DEF,
    parameter int WIDTH = bfr_pkg::NCH * bfr_pkg::CHANNEL_BITS_DEF
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // The read data holds until the next read, so a stalled beat keeps its samples.
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== src/bfr_lane.sv =====
// One channel lane: two window columns, the 9-sample sum and the divide by nine.
`timescale 1ns / 1ps

module bfr_lane #(
    parameter int CHANNEL_BITS = bfr_pkg::CHANNEL_BITS_DEF
) (
    input  logic                         clk,
    input  bfr_pkg::lane_ctl_t           ctl,
    input  logic [CHANNEL_BITS-1:0]      up,
    input  logic [CHANNEL_BITS-1:0]      mid,
    input  logic [CHANNEL_BITS-1:0]      cur,
    output logic [bfr_pkg::OUT_BITS-1:0] mean
);

    localparam int SW = CHANNEL_BITS + 4;
    localparam int K  = SW + 4;
    localparam int PW = SW + K;
    // floor(s / 9) == (s * MULT) >> K for every s below 2**SW.
    localparam logic [K-1:0] MULT = K'((64'd1 << K) / bfr_pkg::DIVISOR + 64'd1);

    // Column x-2 and column x-1 of the window, rows top to bottom.
    logic [2:0][CHANNEL_BITS-1:0] prev2_reg;
    logic [2:0][CHANNEL_BITS-1:0] prev1_reg;
    logic [SW-1:0]                sum_reg;
    logic [SW-1:0]                sum_next;
    logic [PW-1:0]                prod;

    always_comb
    begin
        sum_next = SW'(prev2_reg[0]) + SW'(prev2_reg[1]) + SW'(prev2_reg[2])
                 + SW'(prev1_reg[0]) + SW'(prev1_reg[1]) + SW'(prev1_reg[2])
                 + SW'(up) + SW'(mid) + SW'(cur);
    end

    always_ff @(posedge clk)
    begin
        if (ctl.shift)
        begin
            prev2_reg <= prev1_reg;
            prev1_reg <= {cur, mid, up};
        end
        if (ctl.sum_load)
        begin
            sum_reg <= sum_next;
        end
    end

    assign prod = PW'(sum_reg) * PW'(MULT);
    assign mean = prod[K +: bfr_pkg::OUT_BITS];

endmodule

// ===== src/bfr_merge.sv =====
// Merge stage: gathers the lane means and the center position into the result register.
`timescale 1ns / 1ps

module bfr_merge (
    input  logic                clk,
    input  logic                load,
    input  logic                four_channels,
    input  bfr_pkg::mean_vec_t  means,
    input  bfr_pkg::meta_t      meta,
    output bfr_pkg::pix_out_t   result
);

    bfr_pkg::pix_out_t result_reg;
    bfr_pkg::pix_out_t result_next;

    always_comb
    begin
        result_next.red_out       = means[bfr_pkg::CH_RED];
        result_next.green_out     = means[bfr_pkg::CH_GREEN];
        result_next.blue_out      = means[bfr_pkg::CH_BLUE];
        result_next.alpha_out     = four_channels ? means[bfr_pkg::CH_ALPHA] : '0;
        result_next.center_col    = meta.center_col;
        result_next.center_row    = meta.center_row;
        result_next.last_of_frame = meta.last_of_frame;
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            result_reg <= result_next;
        end
    end

    assign result = result_reg;

endmodule

// ===== tb/tb_box_filter_3x3_rgba_top.sv =====
// Self-checking testbench for the 3x3 box filter: directed frames, random frames and backpressure.
`timescale 1ns / 1ps

module tb_box_filter_3x3_rgba_top;

    localparam int MAX_COLS      = bfr_pkg::MAX_WIDTH_DEF;
    localparam int RANDOM_ITEMS  = 550;
    localparam int CALM_ITEMS    = 150;
    localparam int SETTLE_CYCLES = 8;
    localparam int HOLD_CYCLES   = 400;
    localparam int STALL_LIMIT   = 5000;
    localparam int REPORT_MAX    = 10;
    localparam logic [bfr_pkg::CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

    typedef logic [bfr_pkg::NCH-1:0][bfr_pkg::IN_BITS-1:0] lanes_t;
    typedef enum int {FILL_RANDOM, FILL_EXTREME, FILL_SATURATED, FILL_ZERO} fill_t;

    logic                           clk = 1'b0;
    logic                           rst_n = 1'b0;
    logic                           in_valid = 1'b0;
    logic                           in_ready;
    bfr_pkg::pix_in_t               in_data = '0;
    logic                           out_valid;
    logic                           out_ready = 1'b0;
    bfr_pkg::pix_out_t              out_data;
    logic                           cfg_valid = 1'b0;
    logic                           cfg_ready;
    logic [bfr_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [bfr_pkg::CFG_DATA_W-1:0] cfg_data = '0;

    // Filter state as the block should hold it.
    logic [bfr_pkg::WIDTH_REG_W-1:0]  width_reg;
    logic [bfr_pkg::HEIGHT_REG_W-1:0] height_reg;
    logic                             alpha_en;
    lanes_t                           upper_line [MAX_COLS];
    lanes_t                           middle_line [MAX_COLS];
    lanes_t                           taps [3][3];
    int                               col_pos;
    int                               row_pos;

    bfr_pkg::pix_in_t  pixel_backlog [$];
    bfr_pkg::pix_out_t pending_means [$];
    bfr_pkg::pix_out_t head_mean;

    logic calm = 1'b0;
    logic hold_req = 1'b0;
    logic hold_done = 1'b0;
    int   hold_left = 0;
    int   tx_gap = 0;
    int   rx_gap = 0;
    int   quiet_cycles = 0;
    int   fail_count = 0;
    int   report_count = 0;
    int   pixels_taken = 0;
    int   means_checked = 0;
    int   cfg_writes = 0;
    int   phases = 0;

    box_filter_3x3_rgba_top uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #4 clk = ~clk;

    function automatic int clamp_dim(input int v, input int hi);
        if (v < bfr_pkg::MIN_DIM)
            return bfr_pkg::MIN_DIM;
        if (v > hi)
            return hi;
        return v;
    endfunction

    function automatic void frame_restart();
        col_pos = 0;
        row_pos = 0;
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++)
                taps[i][j] = '0;
    endfunction

    function automatic void filter_reset();
        width_reg  = 12'd640;
        height_reg = 13'd480;
        alpha_en   = 1'b0;
        for (int i = 0; i < MAX_COLS; i++)
        begin
            upper_line[i]  = '0;
            middle_line[i] = '0;
        end
        frame_restart();
    endfunction

    function automatic void filter_config(input logic [bfr_pkg::CFG_IDX_W-1:0] idx,
                                          input logic [bfr_pkg::CFG_DATA_W-1:0] data);
        case (idx)
            bfr_pkg::CFG_IMAGE_WIDTH:   width_reg  = data[bfr_pkg::WIDTH_REG_W-1:0];
            bfr_pkg::CFG_IMAGE_HEIGHT:  height_reg = data[bfr_pkg::HEIGHT_REG_W-1:0];
            bfr_pkg::CFG_FOUR_CHANNELS: alpha_en   = data[0];
            default:                    return;
        endcase
        frame_restart();
    endfunction

    // Advances the window by one pixel and queues the mean of the centered window if any.
    function automatic void box_mean_step(input bfr_pkg::pix_in_t px);
        int                w;
        int                h;
        int                x;
        int                y;
        int                sum;
        lanes_t            cur;
        lanes_t            mean;
        bfr_pkg::pix_out_t res;
        w = clamp_dim(int'(width_reg), MAX_COLS);
        h = clamp_dim(int'(height_reg), bfr_pkg::HEIGHT_LIMIT);
        x = col_pos;
        y = row_pos;
        cur[bfr_pkg::CH_RED]   = px.red_in;
        cur[bfr_pkg::CH_GREEN] = px.green_in;
        cur[bfr_pkg::CH_BLUE]  = px.blue_in;
        cur[bfr_pkg::CH_ALPHA] = px.alpha_in;
        for (int r = 0; r < 3; r++)
        begin
            taps[r][0] = taps[r][1];
            taps[r][1] = taps[r][2];
        end
        taps[0][2] = upper_line[x % MAX_COLS];
        taps[1][2] = middle_line[x % MAX_COLS];
        taps[2][2] = cur;
        upper_line[x % MAX_COLS]  = taps[1][2];
        middle_line[x % MAX_COLS] = cur;
        if (x >= 2 && y >= 2)
        begin
            for (int c = 0; c < bfr_pkg::NCH; c++)
            begin
                sum = 0;
                for (int r = 0; r < 3; r++)
                    for (int k = 0; k < 3; k++)
                        sum += int'(taps[r][k][c]);
                mean[c] = bfr_pkg::OUT_BITS'(sum / bfr_pkg::DIVISOR);
            end
            res.red_out       = mean[bfr_pkg::CH_RED];
            res.green_out     = mean[bfr_pkg::CH_GREEN];
            res.blue_out      = mean[bfr_pkg::CH_BLUE];
            res.alpha_out     = alpha_en ? mean[bfr_pkg::CH_ALPHA] : '0;
            res.center_col    = bfr_pkg::COL_OUT_W'(x - 1);
            res.center_row    = bfr_pkg::ROW_W'(y - 1);
            res.last_of_frame = (x == w - 1) && (y == h - 1);
            pending_means.insert(pending_means.size(), res);
        end
        if (x + 1 >= w)
        begin
            col_pos = 0;
            row_pos = (y + 1 >= h) ? 0 : y + 1;
        end
        else
        begin
            col_pos = x + 1;
        end
    endfunction

    // Pixel driver fed from the backlog.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            in_data  <= '0;
            tx_gap   <= 0;
        end
        else if (in_valid && !in_ready)
        begin
            // The offered beat is held until it is taken.
        end
        else if (tx_gap != 0)
        begin
            in_valid <= 1'b0;
            tx_gap   <= tx_gap - 1;
        end
        else if (pixel_backlog.size() != 0)
        begin
            if (!calm && $urandom_range(0, 7) == 0)
            begin
                in_valid <= 1'b0;
                tx_gap   <= $urandom_range(0, 9);
            end
            else
            begin
                in_valid <= 1'b1;
                in_data  <= pixel_backlog.pop_front();
            end
        end
        else
        begin
            in_valid <= 1'b0;
        end
    end

    // One long receiver hold-off, timed on its own.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_left <= 0;
            hold_done <= 1'b0;
        end
        else if (hold_req && !hold_done)
        begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            rx_gap    <= 0;
        end
        else if (hold_left != 0)
        begin
            out_ready <= 1'b0;
        end
        else if (rx_gap != 0)
        begin
            out_ready <= 1'b0;
            rx_gap    <= rx_gap - 1;
        end
        else if (!calm && $urandom_range(0, 5) == 0)
        begin
            out_ready <= 1'b0;
            rx_gap    <= $urandom_range(0, 9);
        end
        else
        begin
            out_ready <= 1'b1;
        end
    end

    // Monitor: checks result beats, then tracks accepted pixel and register beats.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                means_checked++;
                if (pending_means.size() == 0)
                begin
                    fail_count++;
                    if (report_count < REPORT_MAX)
                    begin
                        report_count++;
                        $display("[%0t] unexpected result beat: col=%0d row=%0d", $realtime,
                                 out_data.center_col, out_data.center_row);
                    end
                end
                else
                begin
                    head_mean = pending_means.pop_front();
                    if (out_data.red_out !== head_mean.red_out
                        || out_data.green_out !== head_mean.green_out
                        || out_data.blue_out !== head_mean.blue_out
                        || out_data.alpha_out !== head_mean.alpha_out
                        || out_data.center_col !== head_mean.center_col
                        || out_data.center_row !== head_mean.center_row
                        || out_data.last_of_frame !== head_mean.last_of_frame)
                    begin
                        fail_count++;
                        if (report_count < REPORT_MAX)
                        begin
                            report_count++;
                            $display("[%0t] mismatch: expected r=%0d g=%0d b=%0d a=%0d %s",
                                     $realtime, head_mean.red_out, head_mean.green_out,
                                     head_mean.blue_out, head_mean.alpha_out,
                                     $sformatf("col=%0d row=%0d last=%0b",
                                               head_mean.center_col, head_mean.center_row,
                                               head_mean.last_of_frame));
                            $display("    actual r=%0d g=%0d b=%0d a=%0d %s",
                                     out_data.red_out, out_data.green_out, out_data.blue_out,
                                     out_data.alpha_out,
                                     $sformatf("col=%0d row=%0d last=%0b",
                                               out_data.center_col, out_data.center_row,
                                               out_data.last_of_frame));
                        end
                    end
                end
            end
            if (in_valid && in_ready)
            begin
                pixels_taken++;
                box_mean_step(in_data);
            end
            if (cfg_valid && cfg_ready)
                filter_config(cfg_index, cfg_data);
        end
    end

    // Watchdog on cycles without any accepted beat.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
            begin
                quiet_cycles <= 0;
            end
            else if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("[%0t] no beat accepted for %0d cycles", $realtime, STALL_LIMIT);
                $display("Verification failed");
                $finish;
            end
            else
            begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    task automatic push_pixels(input int count, input fill_t fill);
        bfr_pkg::pix_in_t px;
        for (int n = 0; n < count; n++)
        begin
            case (fill)
                FILL_RANDOM:
                    px = bfr_pkg::pix_in_t'($urandom);
                FILL_EXTREME:
                begin
                    px.red_in   = $urandom_range(0, 1) ? 8'hFF : 8'h00;
                    px.green_in = $urandom_range(0, 1) ? 8'hFF : 8'h00;
                    px.blue_in  = $urandom_range(0, 1) ? 8'hFF : 8'h00;
                    px.alpha_in = $urandom_range(0, 1) ? 8'hFF : 8'h00;
                end
                FILL_SATURATED:
                    px = '1;
                default:
                    px = '0;
            endcase
            pixel_backlog.insert(pixel_backlog.size(), px);
        end
    endtask

    // Returns once every pixel is in and every mean is out, after a further settling wait.
    task automatic wait_idle();
        while (pixel_backlog.size() != 0 || in_valid || pending_means.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic cfg_write(input logic [bfr_pkg::CFG_IDX_W-1:0] idx,
                             input logic [bfr_pkg::CFG_DATA_W-1:0] data);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        cfg_writes++;
    endtask

    initial
    begin
        int                             n_pix;
        int                             w_eff;
        int                             h_eff;
        int                             random_pushed;
        logic [bfr_pkg::CFG_DATA_W-1:0] wdata;
        logic [bfr_pkg::CFG_DATA_W-1:0] hdata;
        fill_t                          fill;
        random_pushed = 0;
        filter_reset();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // Width 0 and height 2 both clamp to a 3x3 image.
        cfg_write(bfr_pkg::CFG_IMAGE_WIDTH, 13'd0);
        cfg_write(bfr_pkg::CFG_IMAGE_HEIGHT, 13'd2);
        cfg_write(bfr_pkg::CFG_FOUR_CHANNELS, 13'd1);
        push_pixels(9, FILL_SATURATED);
        // The next frame follows the wrap; a write to the spare index must not restart it.
        push_pixels(4, FILL_ZERO);
        wait_idle();
        cfg_write(CFG_SPARE, '1);
        push_pixels(5, FILL_ZERO);
        // RGB only: only bit 0 of the data counts, and alpha must read zero.
        wait_idle();
        cfg_write(bfr_pkg::CFG_FOUR_CHANNELS, 13'h1FFE);
        push_pixels(9, FILL_EXTREME);

        // Widest setting: the width saturates to the line store depth, so a short run
        // stays in row 0 and gives no beat.
        wait_idle();
        cfg_write(bfr_pkg::CFG_IMAGE_WIDTH, 13'h0FFF);
        cfg_write(bfr_pkg::CFG_IMAGE_HEIGHT, 13'd3);
        cfg_write(bfr_pkg::CFG_FOUR_CHANNELS, 13'd1);
        push_pixels(40, FILL_RANDOM);

        // Tallest image, started only; bit 12 of the width data is dropped.
        wait_idle();
        cfg_write(bfr_pkg::CFG_IMAGE_WIDTH, 13'h1003);
        cfg_write(bfr_pkg::CFG_IMAGE_HEIGHT, 13'h1FFF);
        push_pixels(60, FILL_RANDOM);

        // The receiver stops for a long stretch while this frame streams in.
        wait_idle();
        cfg_write(bfr_pkg::CFG_IMAGE_WIDTH, 13'd8);
        cfg_write(bfr_pkg::CFG_IMAGE_HEIGHT, 13'd20);
        hold_req <= 1'b1;
        push_pixels(160, FILL_RANDOM);
        w_eff = 8;
        h_eff = 20;

        while (random_pushed < RANDOM_ITEMS)
        begin
            wait_idle();
            phases++;
            if ($urandom_range(0, 3) != 0)
            begin
                wdata = ($urandom_range(0, 7) == 0) ? 13'($urandom_range(0, 2))
                                                    : 13'($urandom_range(bfr_pkg::MIN_DIM, 20));
                wdata[bfr_pkg::CFG_DATA_W-1] = $urandom_range(0, 1);
                hdata = ($urandom_range(0, 7) == 0) ? 13'($urandom_range(0, 2))
                                                    : 13'($urandom_range(bfr_pkg::MIN_DIM, 8));
                if ($urandom_range(0, 3) != 0)
                begin
                    cfg_write(bfr_pkg::CFG_IMAGE_WIDTH, wdata);
                    w_eff = clamp_dim(int'(wdata[bfr_pkg::WIDTH_REG_W-1:0]), MAX_COLS);
                end
                if ($urandom_range(0, 3) != 0)
                begin
                    cfg_write(bfr_pkg::CFG_IMAGE_HEIGHT, hdata);
                    h_eff = clamp_dim(int'(hdata), bfr_pkg::HEIGHT_LIMIT);
                end
                if ($urandom_range(0, 1) != 0)
                    cfg_write(bfr_pkg::CFG_FOUR_CHANNELS, 13'($urandom));
                if ($urandom_range(0, 5) == 0)
                    cfg_write(CFG_SPARE, 13'($urandom));
            end
            // Mostly whole frames; now and then one is cut short by the next write.
            n_pix = w_eff * h_eff;
            if ($urandom_range(0, 4) == 0)
                n_pix = $urandom_range(1, n_pix - 1);
            else
                n_pix = n_pix * $urandom_range(1, 2);
            fill = ($urandom_range(0, 7) == 0) ? FILL_EXTREME : FILL_RANDOM;
            push_pixels(n_pix, fill);
            random_pushed += n_pix;
            if (random_pushed >= RANDOM_ITEMS - CALM_ITEMS)
                calm <= 1'b1;
        end

        wait_idle();
        $display("Filtered %0d pixels into %0d checked means over %0d register writes.",
                 pixels_taken, means_checked, cfg_writes);
        $display("Random part ran %0d phases of whole and cut frames; %0d failures.",
                 phases, fail_count);
        if (fail_count == 0 && pending_means.size() == 0)
        begin
            $display("Verification passed");
        end
        else
        begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
